FILE: rtl/ora_pkg.sv
// ----------------------------------------------------------------------------
// Ordered resource allocator package
// Sizes, codes and a helper function shared by the allocator core.
// ----------------------------------------------------------------------------
package ora_pkg;

	localparam int RESOURCES  = 16;
	localparam int PROCESSES  = 4;
	localparam int NEED_REGS  = 4;

	localparam int RID_W      = 5;
	localparam int PID_W      = 3;
	localparam int CNT_W      = 5;
	localparam int STATUS_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;
	localparam int PIDX_W     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

	typedef logic [RESOURCES-1:0] res_vec_t;

	typedef enum logic [2:0] {
		PS_RUN  = 3'b001,
		PS_WAIT = 3'b010,
		PS_FIN  = 3'b100
	} proc_state_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANT     = 4'd0,
		ST_BAD_PID   = 4'd1,
		ST_DONE      = 4'd2,
		ST_STILL_WAIT = 4'd3,
		ST_RANGE     = 4'd4,
		ST_HELD      = 4'd5,
		ST_NOW_WAIT  = 4'd6,
		ST_ORDER     = 4'd7,
		ST_TOO_FEW   = 4'd8
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESOURCE_COUNT = 3'd0,
		CFG_PROCESS_COUNT  = 3'd1,
		CFG_ORDERED_MODE   = 3'd2,
		CFG_MAX_NEED_P0    = 3'd3,
		CFG_MAX_NEED_P1    = 3'd4,
		CFG_MAX_NEED_P2    = 3'd5,
		CFG_MAX_NEED_P3    = 3'd6
	} cfg_reg_t;

	function automatic res_vec_t res_bit(input logic [RID_W-1:0] r);
		res_vec_t v;
		for (int i = 0; i < RESOURCES; i++) begin
			v[i] = (r == RID_W'(i + 1));
		end
		return v;
	endfunction

endpackage

FILE: rtl/ordered_resource_allocator_core.sv
// ----------------------------------------------------------------------------
// Ordered resource allocator core
// Grants numbered resources to processes, enforcing ascending order when
// ordered mode is on, and releases a process's resources when it finishes.
// ----------------------------------------------------------------------------
// The core accepts one request per clock cycle unless a result waiting on
// out_ready blocks it, and returns one result for each request: a request
// register feeds a single pass of compare and bitmap logic over the busy map
// and per-process state, and the result register holds the answer while the
// state updates at the same edge, so back-to-back requests from the same
// process see each other's effect. All state lives in flip-flops and is set
// directly by reset, the configuration to its defaults. Configuration writes
// are taken in any cycle and must only be issued while the core is idle.
module ordered_resource_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ora_pkg::PID_W-1:0]     pid,
	input  logic [ora_pkg::RID_W-1:0]     rid,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ora_pkg::STATUS_W-1:0]  status,
	output logic [ora_pkg::RID_W-1:0]     granted_resource,
	output logic                          process_finished,
	output logic                          all_finished,
	output logic [ora_pkg::RID_W-1:0]     allowed_low,
	output logic [ora_pkg::RID_W-1:0]     allowed_high,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ora_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ora_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int RW = ora_pkg::RID_W;
	localparam int CW = ora_pkg::CNT_W;
	localparam int NP = ora_pkg::PROCESSES;

	logic [RW-1:0]               res_count_q;
	logic [ora_pkg::PID_W-1:0]   proc_count_q;
	logic                        ordered_q;
	logic [CW-1:0]               need_q [ora_pkg::NEED_REGS];

	ora_pkg::res_vec_t           busy_q, busy_d;
	ora_pkg::proc_state_t        pstate_q [NP];
	ora_pkg::proc_state_t        pstate_d [NP];
	logic [RW-1:0]               last_q [NP];
	logic [RW-1:0]               last_d [NP];
	logic [RW-1:0]               pend_q [NP];
	logic [RW-1:0]               pend_d [NP];
	logic [CW-1:0]               held_q [NP];
	logic [CW-1:0]               held_d [NP];
	ora_pkg::res_vec_t           hset_q [NP];
	ora_pkg::res_vec_t           hset_d [NP];

	logic                        valid_s1;
	logic [ora_pkg::PID_W-1:0]   pid_s1;
	logic [RW-1:0]               rid_s1;

	logic                        valid_s2;
	ora_pkg::status_t            status_s2;
	logic [RW-1:0]               granted_s2;
	logic                        fin_s2;
	logic                        all_s2;
	logic [RW-1:0]               lo_s2;
	logic [RW-1:0]               hi_s2;

	logic                        advance;
	logic                        fire;
	logic [RW-1:0]               rc;
	logic [ora_pkg::PID_W-1:0]   pc;
	logic [ora_pkg::PIDX_W-1:0]  p;
	logic [CW-1:0]               mx;
	logic [CW-1:0]               need_rem;
	logic [RW-1:0]               left;
	logic [RW:0]                 rc_p1;
	logic [RW:0]                 hi_wide;
	logic                        rid_busy;
	logic                        pend_free;
	logic                        do_grant;
	logic [RW-1:0]               grant_r;
	logic [CW-1:0]               new_cnt;
	logic                        finish;
	ora_pkg::status_t            status_c;
	logic [RW-1:0]               lo_c;
	logic [RW-1:0]               hi_c;
	logic                        all_c;
	ora_pkg::res_vec_t           held_union;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	assign rc = (res_count_q > RW'(ora_pkg::RESOURCES)) ? RW'(ora_pkg::RESOURCES) : res_count_q;
	assign pc = (proc_count_q > ora_pkg::PID_W'(NP)) ? ora_pkg::PID_W'(NP) : proc_count_q;
	assign p  = pid_s1[ora_pkg::PIDX_W-1:0];

	always_comb begin
		mx = '0;
		if (int'(p) < ora_pkg::NEED_REGS) begin
			mx = need_q[p];
		end
	end

	assign need_rem  = (mx > held_q[p]) ? (mx - held_q[p]) : '0;
	assign left      = rc - rid_s1 + RW'(1);
	assign rc_p1     = {1'b0, rc} + (RW+1)'(1);
	assign hi_wide   = ({1'b0, need_rem} > rc_p1) ? '0 : (rc_p1 - {1'b0, need_rem});
	assign rid_busy  = |(busy_q & ora_pkg::res_bit(rid_s1));
	assign pend_free = ~|(busy_q & ora_pkg::res_bit(pend_q[p]));

	always_comb begin
		status_c = ora_pkg::ST_GRANT;
		do_grant = 1'b0;
		grant_r  = '0;
		lo_c     = '0;
		hi_c     = '0;
		busy_d   = busy_q;
		for (int i = 0; i < NP; i++) begin
			pstate_d[i] = pstate_q[i];
			last_d[i]   = last_q[i];
			pend_d[i]   = pend_q[i];
			held_d[i]   = held_q[i];
			hset_d[i]   = hset_q[i];
		end

		if (pid_s1 >= pc) begin
			status_c = ora_pkg::ST_BAD_PID;
		end else if (pstate_q[p] == ora_pkg::PS_FIN) begin
			status_c = ora_pkg::ST_DONE;
		end else if (pstate_q[p] == ora_pkg::PS_WAIT) begin
			if (pend_free) begin
				do_grant = 1'b1;
				grant_r  = pend_q[p];
			end else begin
				status_c = ora_pkg::ST_STILL_WAIT;
			end
		end else if (rid_s1 == '0 || rid_s1 > rc) begin
			pend_d[p] = '0;
			status_c  = ora_pkg::ST_RANGE;
		end else begin
			pend_d[p] = rid_s1;
			if (rid_busy) begin
				if (last_q[p] == rid_s1) begin
					status_c = ora_pkg::ST_HELD;
				end else begin
					pstate_d[p] = ora_pkg::PS_WAIT;
					status_c    = ora_pkg::ST_NOW_WAIT;
				end
			end else if (!ordered_q) begin
				do_grant = 1'b1;
				grant_r  = rid_s1;
			end else if (last_q[p] == '0 && left >= need_rem) begin
				do_grant = 1'b1;
				grant_r  = rid_s1;
			end else if (rid_s1 <= last_q[p]) begin
				status_c = ora_pkg::ST_ORDER;
			end else if (left < need_rem) begin
				status_c = ora_pkg::ST_TOO_FEW;
				lo_c     = last_q[p] + RW'(1);
				hi_c     = hi_wide[RW-1:0];
			end else begin
				do_grant = 1'b1;
				grant_r  = rid_s1;
			end
		end

		new_cnt = held_q[p] + CW'(1);
		finish  = do_grant && (mx == new_cnt);
		if (do_grant) begin
			if (finish) begin
				pstate_d[p] = ora_pkg::PS_FIN;
				busy_d      = busy_q & ~(hset_q[p] | ora_pkg::res_bit(grant_r));
				hset_d[p]   = '0;
				held_d[p]   = '0;
				last_d[p]   = '0;
				pend_d[p]   = '0;
			end else begin
				pstate_d[p] = ora_pkg::PS_RUN;
				busy_d      = busy_q | ora_pkg::res_bit(grant_r);
				hset_d[p]   = hset_q[p] | ora_pkg::res_bit(grant_r);
				held_d[p]   = new_cnt;
				last_d[p]   = grant_r;
			end
		end

		all_c = 1'b1;
		for (int i = 0; i < NP; i++) begin
			if (ora_pkg::PID_W'(i) < pc && pstate_d[i] != ora_pkg::PS_FIN) begin
				all_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_count_q  <= RW'(10);
			proc_count_q <= ora_pkg::PID_W'(3);
			ordered_q    <= 1'b1;
			for (int i = 0; i < ora_pkg::NEED_REGS; i++) begin
				need_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (ora_pkg::cfg_reg_t'(cfg_index))
				ora_pkg::CFG_RESOURCE_COUNT: res_count_q  <= cfg_data[RW-1:0];
				ora_pkg::CFG_PROCESS_COUNT:  proc_count_q <= cfg_data[ora_pkg::PID_W-1:0];
				ora_pkg::CFG_ORDERED_MODE:   ordered_q    <= cfg_data[0];
				ora_pkg::CFG_MAX_NEED_P0:    need_q[0]    <= cfg_data[CW-1:0];
				ora_pkg::CFG_MAX_NEED_P1:    need_q[1]    <= cfg_data[CW-1:0];
				ora_pkg::CFG_MAX_NEED_P2:    need_q[2]    <= cfg_data[CW-1:0];
				ora_pkg::CFG_MAX_NEED_P3:    need_q[3]    <= cfg_data[CW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < NP; i++) begin
				pstate_q[i] <= ora_pkg::PS_RUN;
				last_q[i]   <= '0;
				pend_q[i]   <= '0;
				held_q[i]   <= '0;
				hset_q[i]   <= '0;
			end
		end else if (fire) begin
			busy_q <= busy_d;
			for (int i = 0; i < NP; i++) begin
				pstate_q[i] <= pstate_d[i];
				last_q[i]   <= last_d[i];
				pend_q[i]   <= pend_d[i];
				held_q[i]   <= held_d[i];
				hset_q[i]   <= hset_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pid_s1 <= pid;
			rid_s1 <= rid;
		end
		if (fire) begin
			status_s2  <= status_c;
			granted_s2 <= do_grant ? grant_r : '0;
			fin_s2     <= finish;
			all_s2     <= all_c;
			lo_s2      <= lo_c;
			hi_s2      <= hi_c;
		end
	end

	assign out_valid        = valid_s2;
	assign status           = status_s2;
	assign granted_resource = granted_s2;
	assign process_finished = fin_s2;
	assign all_finished     = all_s2;
	assign allowed_low      = lo_s2;
	assign allowed_high     = hi_s2;

	always_comb begin
		held_union = '0;
		for (int i = 0; i < NP; i++) begin
			held_union = held_union | hset_q[i];
		end
	end

	// The busy map is always exactly the union of the held sets.
	a_busy_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == held_union)
		else $error("busy map differs from union of held sets");

	a_finish_has_grant: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && fin_s2 |-> granted_s2 != '0 && status_s2 == ora_pkg::ST_GRANT)
		else $error("process finished without a grant");

	a_too_few_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == ora_pkg::ST_TOO_FEW |-> lo_s2 != '0 && granted_s2 == '0)
		else $error("too-few-left result without a lower bound");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("request refused while the pipeline can move");

	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed request produced no result");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered resource allocator core testbench
// Drives allocation requests and configuration writes into the core with
// random gaps on both sides. A behavioral copy of the allocator predicts the
// outcome of every accepted request, and each returned result is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int PHASES = 6;

	typedef struct packed {
		logic [ora_pkg::PID_W-1:0] pid;
		logic [ora_pkg::RID_W-1:0] rid;
	} alloc_req_t;

	typedef struct packed {
		ora_pkg::status_t          status;
		logic [ora_pkg::RID_W-1:0] granted;
		logic                      finished;
		logic                      all_done;
		logic [ora_pkg::RID_W-1:0] low;
		logic [ora_pkg::RID_W-1:0] high;
	} alloc_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ora_pkg::PID_W-1:0] pid = '0;
	logic [ora_pkg::RID_W-1:0] rid = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ora_pkg::STATUS_W-1:0] status;
	logic [ora_pkg::RID_W-1:0] granted_resource;
	logic process_finished;
	logic all_finished;
	logic [ora_pkg::RID_W-1:0] allowed_low;
	logic [ora_pkg::RID_W-1:0] allowed_high;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	ora_pkg::cfg_reg_t cfg_index = ora_pkg::CFG_RESOURCE_COUNT;
	logic [ora_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Allocator state as the testbench tracks it.
	logic [ora_pkg::RESOURCES-1:0] busy_map;
	ora_pkg::proc_state_t run_state [ora_pkg::PROCESSES];
	logic [ora_pkg::RID_W-1:0] last_grant [ora_pkg::PROCESSES];
	logic [ora_pkg::RID_W-1:0] wanted [ora_pkg::PROCESSES];
	int held_cnt [ora_pkg::PROCESSES];
	logic [ora_pkg::RESOURCES-1:0] held_map [ora_pkg::PROCESSES];
	logic [ora_pkg::CFG_DATA_W-1:0] res_count_cfg;
	logic [2:0] proc_count_cfg;
	logic ordered_cfg;
	logic [ora_pkg::CFG_DATA_W-1:0] need_cfg [ora_pkg::NEED_REGS];

	alloc_req_t request_q [$];
	alloc_outcome_t outcome_q [$];
	int pushed_total = 0;
	int accepted_total = 0;
	int error_count = 0;
	int stall_cycles = 0;
	int send_idle_pct = 15;
	int recv_idle_pct = 70;
	int hold_left = 0;
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;
	logic req_fire = 1'b0;

	ordered_resource_allocator_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pid              (pid),
		.rid              (rid),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.granted_resource (granted_resource),
		.process_finished (process_finished),
		.all_finished     (all_finished),
		.allowed_low      (allowed_low),
		.allowed_high     (allowed_high),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [ora_pkg::RESOURCES-1:0] res_mask(int r);
		logic [ora_pkg::RESOURCES-1:0] m;
		m = '0;
		if (r >= 1 && r <= ora_pkg::RESOURCES) begin
			m[r-1] = 1'b1;
		end
		return m;
	endfunction

	function automatic int eff_res_count();
		return (res_count_cfg > ora_pkg::RESOURCES) ? ora_pkg::RESOURCES
			: int'(res_count_cfg);
	endfunction

	function automatic int eff_proc_count();
		return (proc_count_cfg > ora_pkg::PROCESSES) ? ora_pkg::PROCESSES
			: int'(proc_count_cfg);
	endfunction

	// Grants the wanted resource and releases everything once the need is met.
	function automatic logic take_resource(int p);
		int r;
		r = wanted[p];
		last_grant[p] = ora_pkg::RID_W'(r);
		held_map[p] |= res_mask(r);
		held_cnt[p]++;
		busy_map |= res_mask(r);
		run_state[p] = ora_pkg::PS_RUN;
		if (int'(need_cfg[p]) == held_cnt[p]) begin
			run_state[p] = ora_pkg::PS_FIN;
			busy_map &= ~held_map[p];
			held_map[p] = '0;
			held_cnt[p] = 0;
			last_grant[p] = '0;
			wanted[p] = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic alloc_outcome_t predict_outcome(int p, int r);
		alloc_outcome_t o;
		int rc;
		int pc;
		int need;
		int left;
		int i;
		logic refused;
		o.status = ora_pkg::ST_GRANT;
		o.granted = '0;
		o.finished = 1'b0;
		o.all_done = 1'b1;
		o.low = '0;
		o.high = '0;
		rc = eff_res_count();
		pc = eff_proc_count();
		if (p >= pc) begin
			o.status = ora_pkg::ST_BAD_PID;
		end else if (run_state[p] == ora_pkg::PS_FIN) begin
			o.status = ora_pkg::ST_DONE;
		end else if (run_state[p] == ora_pkg::PS_WAIT) begin
			if ((busy_map & res_mask(wanted[p])) == '0) begin
				o.granted = wanted[p];
				o.finished = take_resource(p);
			end else begin
				o.status = ora_pkg::ST_STILL_WAIT;
			end
		end else if (r == 0 || r > rc) begin
			wanted[p] = '0;
			o.status = ora_pkg::ST_RANGE;
		end else begin
			wanted[p] = ora_pkg::RID_W'(r);
			if ((busy_map & res_mask(r)) != '0) begin
				if (int'(last_grant[p]) == r) begin
					o.status = ora_pkg::ST_HELD;
				end else begin
					run_state[p] = ora_pkg::PS_WAIT;
					o.status = ora_pkg::ST_NOW_WAIT;
				end
			end else begin
				need = (int'(need_cfg[p]) > held_cnt[p]) ? int'(need_cfg[p]) - held_cnt[p] : 0;
				left = rc - r + 1;
				refused = 1'b0;
				if (ordered_cfg && !(last_grant[p] == 0 && left >= need)) begin
					if (r <= int'(last_grant[p])) begin
						refused = 1'b1;
						o.status = ora_pkg::ST_ORDER;
					end else if (left < need) begin
						refused = 1'b1;
						o.status = ora_pkg::ST_TOO_FEW;
						o.low = ora_pkg::RID_W'(int'(last_grant[p]) + 1);
						o.high = (need > rc + 1) ? '0 : ora_pkg::RID_W'(rc + 1 - need);
					end
				end
				if (!refused) begin
					o.granted = ora_pkg::RID_W'(r);
					o.finished = take_resource(p);
				end
			end
		end
		for (i = 0; i < pc; i++) begin
			if (run_state[i] != ora_pkg::PS_FIN) begin
				o.all_done = 1'b0;
			end
		end
		return o;
	endfunction

	// Mostly ascending requests from live processes, with some noise mixed in.
	function automatic alloc_req_t random_request();
		alloc_req_t q;
		int rc;
		int pc;
		int p;
		int r;
		int roll;
		rc = eff_res_count();
		pc = eff_proc_count();
		roll = $urandom_range(0, 99);
		if (roll < 10 || pc == 0 || rc == 0) begin
			q.pid = ora_pkg::PID_W'($urandom_range(0, 7));
			q.rid = ora_pkg::RID_W'($urandom_range(0, 31));
			return q;
		end
		p = $urandom_range(0, pc - 1);
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			r = int'(last_grant[p]) + $urandom_range(1, 3);
			if (r > rc) begin
				r = $urandom_range(1, rc);
			end
		end else if (roll < 90) begin
			r = $urandom_range(1, rc);
		end else begin
			r = $urandom_range(0, 1) ? 0 : $urandom_range(rc + 1, 31);
		end
		q.pid = ora_pkg::PID_W'(p);
		q.rid = ora_pkg::RID_W'(r);
		return q;
	endfunction

	function automatic void check_field(string label, logic [ora_pkg::RID_W-1:0] want,
			logic [ora_pkg::RID_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			error_count++;
		end
	endfunction

	task automatic add_request(alloc_req_t item);
		request_q.insert(request_q.size(), item);
		pushed_total++;
	endtask

	task automatic push_request(int p, int r);
		alloc_req_t item;
		item.pid = ora_pkg::PID_W'(p);
		item.rid = ora_pkg::RID_W'(r);
		add_request(item);
	endtask

	task automatic wait_drained();
		while (accepted_total != pushed_total || outcome_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(ora_pkg::cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ora_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			ora_pkg::CFG_RESOURCE_COUNT: res_count_cfg = ora_pkg::CFG_DATA_W'(value);
			ora_pkg::CFG_PROCESS_COUNT: proc_count_cfg = 3'(value);
			ora_pkg::CFG_ORDERED_MODE: ordered_cfg = 1'(value);
			default: need_cfg[int'(idx) - int'(ora_pkg::CFG_MAX_NEED_P0)] =
				ora_pkg::CFG_DATA_W'(value);
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_needs(int n0, int n1, int n2, int n3);
		write_reg(ora_pkg::CFG_MAX_NEED_P0, n0);
		write_reg(ora_pkg::CFG_MAX_NEED_P1, n1);
		write_reg(ora_pkg::CFG_MAX_NEED_P2, n2);
		write_reg(ora_pkg::CFG_MAX_NEED_P3, n3);
	endtask

	function automatic int random_need();
		return ($urandom_range(0, 99) < 60) ? $urandom_range(1, 6) : $urandom_range(0, 31);
	endfunction

	// Request driver.
	always @(negedge clk) begin
		alloc_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_fire) begin
			if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = request_q.pop_front();
				in_valid <= 1'b1;
				pid <= nxt.pid;
				rid <= nxt.rid;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off to back the core up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: checks results, predicts accepted requests, watches for hangs.
	always @(posedge clk) begin
		alloc_outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				error_count++;
			end else begin
				want = outcome_q.pop_front();
				check_field("status", ora_pkg::RID_W'(want.status), ora_pkg::RID_W'(status));
				check_field("granted_resource", want.granted, granted_resource);
				check_field("process_finished", ora_pkg::RID_W'(want.finished),
					ora_pkg::RID_W'(process_finished));
				check_field("all_finished", ora_pkg::RID_W'(want.all_done),
					ora_pkg::RID_W'(all_finished));
				check_field("allowed_low", want.low, allowed_low);
				check_field("allowed_high", want.high, allowed_high);
			end
		end
		req_fire = arst_n && in_valid && in_ready;
		if (req_fire) begin
			outcome_q.insert(outcome_q.size(), predict_outcome(int'(pid), int'(rid)));
			accepted_total++;
		end
		if (!arst_n || req_fire || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int s;
		int k;
		int rc_plan [PHASES];
		int pc_plan [PHASES];
		int ord_plan [PHASES];
		rc_plan = '{12, 1, 16, 5, 31, 9};
		pc_plan = '{4, 2, 4, 3, 7, 4};
		ord_plan = '{1, 1, 0, 1, 1, 0};
		busy_map = '0;
		for (k = 0; k < ora_pkg::PROCESSES; k++) begin
			run_state[k] = ora_pkg::PS_RUN;
			last_grant[k] = '0;
			wanted[k] = '0;
			held_cnt[k] = 0;
			held_map[k] = '0;
			need_cfg[k] = '0;
		end
		res_count_cfg = 5'd10;
		proc_count_cfg = 3'd3;
		ordered_cfg = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(ora_pkg::CFG_RESOURCE_COUNT, 16);
		write_reg(ora_pkg::CFG_PROCESS_COUNT, 4);
		write_reg(ora_pkg::CFG_ORDERED_MODE, 1);
		write_needs(3, 2, 31, 0);
		push_request(7, 5);
		push_request(0, 0);
		push_request(0, 17);
		push_request(0, 31);
		push_request(0, 15);
		push_request(0, 2);
		push_request(0, 2);
		push_request(0, 1);
		push_request(1, 2);
		push_request(1, 9);
		push_request(0, 16);
		push_request(0, 5);
		push_request(0, 9);
		push_request(0, 3);
		push_request(1, 0);
		push_request(2, 1);
		push_request(3, 16);
		wait_drained();
		write_reg(ora_pkg::CFG_PROCESS_COUNT, 1);
		push_request(1, 4);
		push_request(0, 4);
		wait_drained();
		write_reg(ora_pkg::CFG_PROCESS_COUNT, 0);
		push_request(0, 1);
		wait_drained();
		write_reg(ora_pkg::CFG_PROCESS_COUNT, 7);
		write_reg(ora_pkg::CFG_ORDERED_MODE, 0);
		write_reg(ora_pkg::CFG_RESOURCE_COUNT, 31);
		push_request(2, 8);
		push_request(2, 3);
		push_request(3, 16);
		wait_drained();

		for (s = 0; s < PHASES; s++) begin
			@(posedge clk);
			send_idle_pct = (s < 2) ? 15 : (s < 4) ? 70 : 0;
			recv_idle_pct = (s < 2) ? 70 : (s < 4) ? 15 : 0;
			write_reg(ora_pkg::CFG_RESOURCE_COUNT, rc_plan[s]);
			write_reg(ora_pkg::CFG_PROCESS_COUNT, pc_plan[s]);
			write_reg(ora_pkg::CFG_ORDERED_MODE, ord_plan[s]);
			write_needs(random_need(), random_need(), random_need(), random_need());
			if (s == 4) begin
				@(posedge clk);
				hold_armed = 1'b1;
			end
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				while (request_q.size() >= 4) begin
					@(negedge clk);
				end
				add_request(random_request());
			end
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (error_count == 0 && outcome_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
